>>> rtl/gatq_pkg.sv
// ----------------------------------------------------------------------------
// gatq_pkg: shared types and constants for the grasp axes to quaternion block
// Widths of the fixed point stages and the payload of the square root and
// divider pipeline stages.
// ----------------------------------------------------------------------------
package gatq_pkg;

    localparam int QW    = 16;   // Q1.14 vector and quaternion components
    localparam int PW    = 32;   // position words
    localparam int KW    = 33;   // first frame axis in Q.28
    localparam int BPW   = 49;   // products of the second cross product
    localparam int BW    = 50;   // second frame axis in Q.42
    localparam int VW    = 52;   // branch values of the trace method, Q.42
    localparam int HIW   = VW - 30;  // magnitude bits above the normalized range
    localparam int SHW   = 5;    // normalizing shift count
    localparam int MW    = 30;   // normalized magnitudes
    localparam int SQW   = 2 * MW;   // one square
    localparam int SUMW  = 62;   // sum of four squares
    localparam int ROOTW = 31;   // integer square root
    localparam int RQW   = 15;   // quotient bits of the final scaling
    localparam int NUMW  = 47;   // divider numerator and shifted divisor

    localparam logic signed [VW-1:0] ONE_Q42 = VW'(1) <<< 42;

    typedef struct packed {
        logic [SUMW-1:0]        rem;
        logic [ROOTW-1:0]       root;
        logic [3:0][MW-1:0]     mag;
        logic [3:0]             neg;
        logic                   degen;
        logic [2:0][PW-1:0]     pos;
    } sq_stage_t;

    typedef struct packed {
        logic [NUMW-1:0]        dvs;
        logic [3:0][NUMW-1:0]   rem;
        logic [3:0][RQW-1:0]    quo;
        logic [3:0]             neg;
        logic                   degen;
        logic [2:0][PW-1:0]     pos;
    } dv_stage_t;

endpackage

>>> rtl/grasp_axes_to_quaternion.sv
// ----------------------------------------------------------------------------
// grasp_axes_to_quaternion: grasp frame to unit quaternion
// Builds a frame from the up and approach vectors, converts it with the
// four-branch trace method, normalizes it to Q1.14 and copies the position.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; busy is never raised. The request
// passes ten arithmetic front stages, then the 31-step square root and the
// 15-step divider, each one bit per pipeline stage, and the output register.
// Reset clears all stage valid bits and done; data registers are not reset.
module grasp_axes_to_quaternion (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [gatq_pkg::QW-1:0]    up_x,
    input  logic signed [gatq_pkg::QW-1:0]    up_y,
    input  logic signed [gatq_pkg::QW-1:0]    up_z,
    input  logic signed [gatq_pkg::QW-1:0]    approach_x,
    input  logic signed [gatq_pkg::QW-1:0]    approach_y,
    input  logic signed [gatq_pkg::QW-1:0]    approach_z,
    input  logic signed [gatq_pkg::PW-1:0]    position_x,
    input  logic signed [gatq_pkg::PW-1:0]    position_y,
    input  logic signed [gatq_pkg::PW-1:0]    position_z,
    output logic                              done,
    output logic signed [gatq_pkg::QW-1:0]    quat_x,
    output logic signed [gatq_pkg::QW-1:0]    quat_y,
    output logic signed [gatq_pkg::QW-1:0]    quat_z,
    output logic signed [gatq_pkg::QW-1:0]    quat_w,
    output logic signed [gatq_pkg::PW-1:0]    pos_out_x,
    output logic signed [gatq_pkg::PW-1:0]    pos_out_y,
    output logic signed [gatq_pkg::PW-1:0]    pos_out_z,
    output logic                              degenerate
);
    import gatq_pkg::*;

    localparam int NFRONT = 10;

    logic accept;
    logic [NFRONT-1:0] vld_reg;

    logic signed [2*QW-1:0] p1_prod_reg [6];
    logic signed [QW-1:0]   p1_c_reg    [3];
    logic [2:0][PW-1:0]     p1_pos_reg;

    logic signed [KW-1:0]   p2_k_reg [3];
    logic signed [QW-1:0]   p2_c_reg [3];
    logic [2:0][PW-1:0]     p2_pos_reg;

    logic signed [BPW-1:0]  p3_prod_reg [6];
    logic signed [KW-1:0]   p3_k_reg [3];
    logic signed [QW-1:0]   p3_c_reg [3];
    logic [2:0][PW-1:0]     p3_pos_reg;

    logic signed [BW-1:0]   p4_b_reg [3];
    logic signed [KW-1:0]   p4_k_reg [3];
    logic signed [QW-1:0]   p4_c_reg [3];
    logic [2:0][PW-1:0]     p4_pos_reg;

    logic signed [VW-1:0]   p5_k_next [3];
    logic signed [VW-1:0]   p5_b_next [3];
    logic signed [VW-1:0]   p5_c_next [3];
    logic signed [VW-1:0]   p5_k_reg [3];
    logic signed [VW-1:0]   p5_b_reg [3];
    logic signed [VW-1:0]   p5_c_reg [3];
    logic signed [VW-1:0]   p5_t_reg;
    logic                   p5_kb_reg;
    logic                   p5_kc_reg;
    logic                   p5_bc_reg;
    logic [2:0][PW-1:0]     p5_pos_reg;

    logic signed [VW-1:0]   p6_q_next [4];
    logic signed [VW-1:0]   p6_s_next;
    logic signed [VW-1:0]   p6_q_reg [4];
    logic                   p6_degen_reg;
    logic [2:0][PW-1:0]     p6_pos_reg;

    logic [VW-1:0]          p7_mag_reg [4];
    logic [3:0]             p7_neg_reg;
    logic                   p7_degen_reg;
    logic [2:0][PW-1:0]     p7_pos_reg;

    logic [VW-1:0]          p8_or;
    logic [VW-1:0]          p8_mag_reg [4];
    logic [SHW-1:0]         p8_sh_reg;
    logic [3:0]             p8_neg_reg;
    logic                   p8_degen_reg;
    logic [2:0][PW-1:0]     p8_pos_reg;

    logic [3:0][MW-1:0]     p9_mag_reg;
    logic [3:0]             p9_neg_reg;
    logic                   p9_degen_reg;
    logic [2:0][PW-1:0]     p9_pos_reg;

    logic [SQW-1:0]         p10_sq_reg [4];
    logic [3:0][MW-1:0]     p10_mag_reg;
    logic [3:0]             p10_neg_reg;
    logic                   p10_degen_reg;
    logic [2:0][PW-1:0]     p10_pos_reg;

    sq_stage_t              sq_reg [0:ROOTW];
    sq_stage_t              sq_next [ROOTW];
    logic [ROOTW:0]         sq_vld_reg;

    dv_stage_t              dv_reg [0:RQW];
    dv_stage_t              dv_next [RQW];
    logic [RQW:0]           dv_vld_reg;

    logic                   done_reg;
    logic signed [QW-1:0]   quat_reg [4];
    logic [2:0][PW-1:0]     pos_reg;
    logic                   degen_reg;

    // Shift that brings the largest magnitude below 2^30: the bit length of
    // the bits above that range.
    function automatic logic [SHW-1:0] norm_shift(input logic [HIW-1:0] hi);
        logic [SHW-1:0] sh;
        sh = '0;
        for (int i = 0; i < HIW; i++)
        begin
            if (hi[i])
            begin
                sh = SHW'(i + 1);
            end
        end
        return sh;
    endfunction

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Valid bits of all stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            sq_vld_reg <= '0;
            dv_vld_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            vld_reg    <= {vld_reg[NFRONT-2:0], accept};
            sq_vld_reg <= {sq_vld_reg[ROOTW-1:0], vld_reg[NFRONT-1]};
            dv_vld_reg <= {dv_vld_reg[RQW-1:0], sq_vld_reg[ROOTW]};
            done_reg   <= dv_vld_reg[RQW];
        end
    end

    // Stages 1 to 4: the two cross products, kept exact.
    always_ff @(posedge clk)
    begin
        p1_prod_reg[0] <= up_y * approach_z;
        p1_prod_reg[1] <= up_z * approach_y;
        p1_prod_reg[2] <= up_z * approach_x;
        p1_prod_reg[3] <= up_x * approach_z;
        p1_prod_reg[4] <= up_x * approach_y;
        p1_prod_reg[5] <= up_y * approach_x;
        p1_c_reg[0]    <= approach_x;
        p1_c_reg[1]    <= approach_y;
        p1_c_reg[2]    <= approach_z;
        p1_pos_reg     <= {position_z, position_y, position_x};

        for (int i = 0; i < 3; i++)
        begin
            p2_k_reg[i] <= KW'(p1_prod_reg[2*i]) - KW'(p1_prod_reg[2*i+1]);
        end
        p2_c_reg   <= p1_c_reg;
        p2_pos_reg <= p1_pos_reg;

        p3_prod_reg[0] <= BPW'(p2_c_reg[1]) * BPW'(p2_k_reg[2]);
        p3_prod_reg[1] <= BPW'(p2_c_reg[2]) * BPW'(p2_k_reg[1]);
        p3_prod_reg[2] <= BPW'(p2_c_reg[2]) * BPW'(p2_k_reg[0]);
        p3_prod_reg[3] <= BPW'(p2_c_reg[0]) * BPW'(p2_k_reg[2]);
        p3_prod_reg[4] <= BPW'(p2_c_reg[0]) * BPW'(p2_k_reg[1]);
        p3_prod_reg[5] <= BPW'(p2_c_reg[1]) * BPW'(p2_k_reg[0]);
        p3_k_reg       <= p2_k_reg;
        p3_c_reg       <= p2_c_reg;
        p3_pos_reg     <= p2_pos_reg;

        for (int i = 0; i < 3; i++)
        begin
            p4_b_reg[i] <= BW'(p3_prod_reg[2*i]) - BW'(p3_prod_reg[2*i+1]);
        end
        p4_k_reg   <= p3_k_reg;
        p4_c_reg   <= p3_c_reg;
        p4_pos_reg <= p3_pos_reg;
    end

    // Stage 5: all three axes in Q.42, trace and branch compares.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p5_k_next[i] = VW'(p4_k_reg[i]) <<< 14;
            p5_b_next[i] = VW'(p4_b_reg[i]);
            p5_c_next[i] = VW'(p4_c_reg[i]) <<< 28;
        end
    end

    always_ff @(posedge clk)
    begin
        p5_k_reg   <= p5_k_next;
        p5_b_reg   <= p5_b_next;
        p5_c_reg   <= p5_c_next;
        p5_t_reg   <= p5_k_next[0] + p5_b_next[1] + p5_c_next[2];
        p5_kb_reg  <= p5_k_next[0] >= p5_b_next[1];
        p5_kc_reg  <= p5_k_next[0] >= p5_c_next[2];
        p5_bc_reg  <= p5_b_next[1] > p5_c_next[2];
        p5_pos_reg <= p4_pos_reg;
    end

    // Stage 6: the trace method branch, unscaled.
    always_comb
    begin
        priority if (p5_t_reg > 0)
        begin
            p6_s_next    = p5_t_reg + ONE_Q42;
            p6_q_next[0] = p5_b_reg[2] - p5_c_reg[1];
            p6_q_next[1] = p5_c_reg[0] - p5_k_reg[2];
            p6_q_next[2] = p5_k_reg[1] - p5_b_reg[0];
            p6_q_next[3] = p6_s_next;
        end
        else if (p5_kb_reg && p5_kc_reg)
        begin
            p6_s_next    = ONE_Q42 + p5_k_reg[0] - p5_b_reg[1] - p5_c_reg[2];
            p6_q_next[0] = p6_s_next;
            p6_q_next[1] = p5_k_reg[1] + p5_b_reg[0];
            p6_q_next[2] = p5_k_reg[2] + p5_c_reg[0];
            p6_q_next[3] = p5_b_reg[2] - p5_c_reg[1];
        end
        else if (p5_bc_reg)
        begin
            p6_s_next    = ONE_Q42 + p5_b_reg[1] - p5_k_reg[0] - p5_c_reg[2];
            p6_q_next[0] = p5_b_reg[0] + p5_k_reg[1];
            p6_q_next[1] = p6_s_next;
            p6_q_next[2] = p5_c_reg[1] + p5_b_reg[2];
            p6_q_next[3] = p5_c_reg[0] - p5_k_reg[2];
        end
        else
        begin
            p6_s_next    = ONE_Q42 + p5_c_reg[2] - p5_k_reg[0] - p5_b_reg[1];
            p6_q_next[0] = p5_c_reg[0] + p5_k_reg[2];
            p6_q_next[1] = p5_c_reg[1] + p5_b_reg[2];
            p6_q_next[2] = p6_s_next;
            p6_q_next[3] = p5_k_reg[1] - p5_b_reg[0];
        end
    end

    assign p8_or = p7_mag_reg[0] | p7_mag_reg[1] | p7_mag_reg[2] | p7_mag_reg[3];

    // Stages 6 to 10: magnitudes, normalizing shift, squares.
    always_ff @(posedge clk)
    begin
        p6_q_reg     <= p6_q_next;
        p6_degen_reg <= p6_s_next <= 0;
        p6_pos_reg   <= p5_pos_reg;

        for (int i = 0; i < 4; i++)
        begin
            p7_neg_reg[i] <= p6_q_reg[i][VW-1];
            p7_mag_reg[i] <= p6_q_reg[i][VW-1] ? VW'(-p6_q_reg[i]) : VW'(p6_q_reg[i]);
        end
        p7_degen_reg <= p6_degen_reg;
        p7_pos_reg   <= p6_pos_reg;

        // The bit length of the OR equals that of the largest magnitude.
        p8_sh_reg    <= norm_shift(p8_or[VW-1:MW]);
        p8_mag_reg   <= p7_mag_reg;
        p8_neg_reg   <= p7_neg_reg;
        p8_degen_reg <= p7_degen_reg;
        p8_pos_reg   <= p7_pos_reg;

        for (int i = 0; i < 4; i++)
        begin
            p9_mag_reg[i] <= MW'(p8_mag_reg[i] >> p8_sh_reg);
        end
        p9_neg_reg   <= p8_neg_reg;
        p9_degen_reg <= p8_degen_reg;
        p9_pos_reg   <= p8_pos_reg;

        for (int i = 0; i < 4; i++)
        begin
            p10_sq_reg[i] <= SQW'(p9_mag_reg[i]) * SQW'(p9_mag_reg[i]);
        end
        p10_mag_reg   <= p9_mag_reg;
        p10_neg_reg   <= p9_neg_reg;
        p10_degen_reg <= p9_degen_reg;
        p10_pos_reg   <= p9_pos_reg;
    end

    // Square root, one root bit per stage from the top.
    always_comb
    begin
        logic [SUMW:0] trial;
        for (int g = 0; g < ROOTW; g++)
        begin
            trial = ((SUMW+1)'(sq_reg[g].root) << (ROOTW - g))
                  + ((SUMW+1)'(1) << (2 * (ROOTW - 1 - g)));
            sq_next[g] = sq_reg[g];
            if ({1'b0, sq_reg[g].rem} >= trial)
            begin
                sq_next[g].rem  = SUMW'({1'b0, sq_reg[g].rem} - trial);
                sq_next[g].root = sq_reg[g].root | (ROOTW'(1) << (ROOTW - 1 - g));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg[0].rem   <= SUMW'(p10_sq_reg[0]) + SUMW'(p10_sq_reg[1])
                         + SUMW'(p10_sq_reg[2]) + SUMW'(p10_sq_reg[3]);
        sq_reg[0].root  <= '0;
        sq_reg[0].mag   <= p10_mag_reg;
        sq_reg[0].neg   <= p10_neg_reg;
        sq_reg[0].degen <= p10_degen_reg;
        sq_reg[0].pos   <= p10_pos_reg;
        for (int g = 0; g < ROOTW; g++)
        begin
            sq_reg[g+1] <= sq_next[g];
        end
    end

    // Restoring division, one quotient bit per stage in four lanes.
    always_comb
    begin
        logic [NUMW-1:0] sub;
        for (int j = 0; j < RQW; j++)
        begin
            sub = dv_reg[j].dvs << (RQW - 1 - j);
            dv_next[j] = dv_reg[j];
            for (int l = 0; l < 4; l++)
            begin
                if (dv_reg[j].rem[l] >= sub)
                begin
                    dv_next[j].rem[l]              = dv_reg[j].rem[l] - sub;
                    dv_next[j].quo[l][RQW - 1 - j] = 1'b1;
                end
            end
        end
    end

    // Divider setup: numerator is mag * 2^15 + M, divisor 2 * M.
    always_ff @(posedge clk)
    begin
        dv_reg[0].dvs <= NUMW'({sq_reg[ROOTW].root, 1'b0});
        for (int i = 0; i < 4; i++)
        begin
            dv_reg[0].rem[i] <= (NUMW'(sq_reg[ROOTW].mag[i]) << RQW)
                              + NUMW'(sq_reg[ROOTW].root);
        end
        dv_reg[0].quo   <= '0;
        dv_reg[0].neg   <= sq_reg[ROOTW].neg;
        dv_reg[0].degen <= sq_reg[ROOTW].degen || (sq_reg[ROOTW].root == '0);
        dv_reg[0].pos   <= sq_reg[ROOTW].pos;
        for (int j = 0; j < RQW; j++)
        begin
            dv_reg[j+1] <= dv_next[j];
        end
    end

    // Output register: sign, degenerate zeroing, position.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (dv_reg[RQW].degen)
            begin
                quat_reg[i] <= '0;
            end
            else if (dv_reg[RQW].neg[i])
            begin
                quat_reg[i] <= -QW'(dv_reg[RQW].quo[i]);
            end
            else
            begin
                quat_reg[i] <= QW'(dv_reg[RQW].quo[i]);
            end
        end
        pos_reg   <= dv_reg[RQW].pos;
        degen_reg <= dv_reg[RQW].degen;
    end

    assign done       = done_reg;
    assign quat_x     = quat_reg[0];
    assign quat_y     = quat_reg[1];
    assign quat_z     = quat_reg[2];
    assign quat_w     = quat_reg[3];
    assign pos_out_x  = pos_reg[0];
    assign pos_out_y  = pos_reg[1];
    assign pos_out_z  = pos_reg[2];
    assign degenerate = degen_reg;

endmodule

>>> bench/grasp_axes_to_quaternion_tb.sv
// ----------------------------------------------------------------------------
// grasp_axes_to_quaternion_tb: self-checking bench for the grasp quaternion
// A directed table of vector pairs is followed by random frames and raw
// vectors. Every request is predicted in integer arithmetic; each done result
// is compared field by field with the oldest known pose or prediction.
// ----------------------------------------------------------------------------
module grasp_axes_to_quaternion_tb;

    import gatq_pkg::*;

    typedef struct packed {
        logic signed [QW-1:0] qx, qy, qz, qw;
        logic signed [PW-1:0] px, py, pz;
        logic                 degen;
    } pose_t;

    typedef struct {
        logic signed [QW-1:0] ux, uy, uz, ax, ay, az;
        logic signed [PW-1:0] px, py, pz;
        bit                   has_known;
        pose_t                known;
    } grasp_row_t;

    localparam int NUM_RANDOM = 1500;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LATENCY = 59;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [QW-1:0] up_x = '0, up_y = '0, up_z = '0;
    logic signed [QW-1:0] approach_x = '0, approach_y = '0, approach_z = '0;
    logic signed [PW-1:0] position_x = '0, position_y = '0, position_z = '0;
    logic done;
    logic signed [QW-1:0] quat_x, quat_y, quat_z, quat_w;
    logic signed [PW-1:0] pos_out_x, pos_out_y, pos_out_z;
    logic degenerate;

    pose_t      pending_poses[$];
    grasp_row_t grasp_table[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         results_seen = 0;
    int         degen_seen = 0;

    grasp_axes_to_quaternion DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic void add_row(grasp_row_t g);
        grasp_table.insert(grasp_table.size(), g);
    endfunction

    function automatic longint unsigned isqrt_u64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic pose_t predict_pose(grasp_row_t g);
        pose_t p;
        longint u[3], c14[3], k28[3], k[3], b[3], c[3], q[4], s;
        longint unsigned mg[4], mx, sum, m, r;
        bit neg[4];
        bit degen;
        int sh;
        u[0] = g.ux; u[1] = g.uy; u[2] = g.uz;
        c14[0] = g.ax; c14[1] = g.ay; c14[2] = g.az;
        mx = 0; sum = 0; sh = 0; degen = 0;
        k28[0] = u[1] * c14[2] - u[2] * c14[1];
        k28[1] = u[2] * c14[0] - u[0] * c14[2];
        k28[2] = u[0] * c14[1] - u[1] * c14[0];
        b[0] = c14[1] * k28[2] - c14[2] * k28[1];
        b[1] = c14[2] * k28[0] - c14[0] * k28[2];
        b[2] = c14[0] * k28[1] - c14[1] * k28[0];
        for (int i = 0; i < 3; i++)
        begin
            k[i] = k28[i] <<< 14;
            c[i] = c14[i] <<< 28;
        end
        s = k[0] + b[1] + c[2];
        if (s > 0)
        begin
            s += 64'sd1 <<< 42;
            q[0] = b[2] - c[1]; q[1] = c[0] - k[2]; q[2] = k[1] - b[0]; q[3] = s;
        end
        else if (k[0] >= b[1] && k[0] >= c[2])
        begin
            s = (64'sd1 <<< 42) + k[0] - b[1] - c[2];
            q[0] = s; q[1] = k[1] + b[0]; q[2] = k[2] + c[0]; q[3] = b[2] - c[1];
        end
        else if (b[1] > c[2])
        begin
            s = (64'sd1 <<< 42) + b[1] - k[0] - c[2];
            q[0] = b[0] + k[1]; q[1] = s; q[2] = c[1] + b[2]; q[3] = c[0] - k[2];
        end
        else
        begin
            s = (64'sd1 <<< 42) + c[2] - k[0] - b[1];
            q[0] = c[0] + k[2]; q[1] = c[1] + b[2]; q[2] = s; q[3] = k[1] - b[0];
        end
        if (s <= 0)
            degen = 1;
        for (int i = 0; i < 4; i++)
        begin
            neg[i] = q[i] < 0;
            mg[i] = neg[i] ? -q[i] : q[i];
            if (mg[i] > mx)
                mx = mg[i];
        end
        while ((mx >> sh) >= (64'd1 << 30))
            sh++;
        for (int i = 0; i < 4; i++)
        begin
            mg[i] >>= sh;
            sum += mg[i] * mg[i];
        end
        m = isqrt_u64(sum);
        if (m == 0)
            degen = 1;
        for (int i = 0; i < 4; i++)
        begin
            r = 0;
            if (!degen)
                r = ((mg[i] << 15) + m) / (2 * m);
            if (neg[i])
                r = -r;
            q[i] = longint'(r);
        end
        p.qx = q[0][QW-1:0]; p.qy = q[1][QW-1:0];
        p.qz = q[2][QW-1:0]; p.qw = q[3][QW-1:0];
        p.px = g.px; p.py = g.py; p.pz = g.pz;
        p.degen = degen;
        return p;
    endfunction

    function automatic grasp_row_t make_row(int ux, int uy, int uz, int ax, int ay,
                                            int az, int px, int py, int pz);
        grasp_row_t g;
        g.ux = QW'(ux); g.uy = QW'(uy); g.uz = QW'(uz);
        g.ax = QW'(ax); g.ay = QW'(ay); g.az = QW'(az);
        g.px = px; g.py = py; g.pz = pz;
        g.has_known = 0;
        g.known = '0;
        return g;
    endfunction

    function automatic pose_t known_pose(int qx, int qy, int qz, int qw,
                                         grasp_row_t g, bit degen);
        pose_t p;
        p.qx = QW'(qx); p.qy = QW'(qy); p.qz = QW'(qz); p.qw = QW'(qw);
        p.px = g.px; p.py = g.py; p.pz = g.pz;
        p.degen = degen;
        return p;
    endfunction

    function automatic logic signed [QW-1:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            default: return QW'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    // A well-formed grasp uses unit-ish axes; the rest is raw noise.
    function automatic grasp_row_t random_row();
        grasp_row_t g;
        g = make_row(0, 0, 0, 0, 0, 0, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 3) != 0)
        begin
            g.ux = rand_axis(); g.uy = rand_axis(); g.uz = rand_axis();
            g.ax = rand_axis(); g.ay = rand_axis(); g.az = rand_axis();
        end
        else
        begin
            g.ux = QW'($urandom); g.uy = QW'($urandom); g.uz = QW'($urandom);
            g.ax = QW'($urandom); g.ay = QW'($urandom); g.az = QW'($urandom);
        end
        return g;
    endfunction

    task automatic send_request(grasp_row_t g);
        pose_t p;
        up_x <= g.ux; up_y <= g.uy; up_z <= g.uz;
        approach_x <= g.ax; approach_y <= g.ay; approach_z <= g.az;
        position_x <= g.px; position_y <= g.py; position_z <= g.pz;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        p = predict_pose(g);
        if (g.has_known && p != g.known)
            $display("table row disagrees with prediction: u=%0d,%0d,%0d",
                     g.ux, g.uy, g.uz);
        pending_poses.insert(pending_poses.size(), g.has_known ? g.known : p);
    endtask

    task automatic idle_gap();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: n = 0;
            5, 6, 7, 8: n = $urandom_range(1, 3);
            default: n = $urandom_range(10, 80);
        endcase
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        pose_t e;
        if (rst_n && done)
        begin
            results_seen++;
            if (degenerate)
                degen_seen++;
            if (pending_poses.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result with no request outstanding");
            end
            else
            begin
                e = pending_poses.pop_front();
                if (quat_x !== e.qx || quat_y !== e.qy || quat_z !== e.qz ||
                    quat_w !== e.qw || pos_out_x !== e.px || pos_out_y !== e.py ||
                    pos_out_z !== e.pz || degenerate !== e.degen)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch: exp q=%0d %0d %0d %0d p=%0d %0d %0d d=%0b",
                                 e.qx, e.qy, e.qz, e.qw, e.px, e.py, e.pz, e.degen);
                        $display("          got q=%0d %0d %0d %0d p=%0d %0d %0d d=%0b",
                                 quat_x, quat_y, quat_z, quat_w,
                                 pos_out_x, pos_out_y, pos_out_z, degenerate);
                    end
                end
            end
        end
    end

    initial
    begin
        grasp_row_t g;
        int wait_cycles;
        // Identity frame: up x approach = x axis, approach = z axis.
        g = make_row(0, 16384, 0, 0, 0, 16384, 1, 2, 3);
        g.has_known = 1; g.known = known_pose(0, 0, 0, 16384, g, 0);
        add_row(g);
        // Zero vectors give a zero trace and fall into the x branch with a
        // root argument of one.
        g = make_row(0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0);
        g.has_known = 1; g.known = known_pose(16384, 0, 0, 0, g, 0);
        add_row(g);
        // Extremes: vector components at their most negative or most positive values.
        add_row(make_row(-32768, -32768, -32768, -32768, -32768, -32768,
                         -1, -1, -1));
        add_row(make_row(32767, 32767, 32767, 32767, 32767, 32767,
                         32'h7fffffff, 0, 32'h80000000));
        add_row(make_row(32767, -32768, 0, -32768, 32767, 0, 5, 6, 7));
        add_row(make_row(-32768, 0, 0, 0, -32768, 0, 0, 0, 0));
        // Branches of the trace method: w and x dominant frames.
        add_row(make_row(0, -16384, 0, 0, 0, -16384, 10, 0, 0));
        add_row(make_row(0, 0, 16384, 0, -16384, 0, 0, 11, 0));
        add_row(make_row(0, 0, -16384, 0, 16384, 0, 0, 0, 12));
        add_row(make_row(16384, 0, 0, 0, 0, -16384, 13, 0, 0));
        add_row(make_row(0, 16384, 0, 16384, 0, 0, 0, 14, 0));
        add_row(make_row(16384, 16384, 0, 0, 0, 16384, 0, 0, 15));
        // Non-frame inputs: a zero up vector or parallel axes, which leave the first two frame axes zero.
        add_row(make_row(0, 0, 0, 0, 0, -16384, 16, 17, 18));
        add_row(make_row(0, 0, 0, -16384, 0, 0, 19, 20, 21));
        add_row(make_row(0, 0, 0, 0, 0, -32768, 22, 23, 24));
        add_row(make_row(16384, 0, 0, 16384, 0, 0, 25, 26, 27));
        add_row(make_row(0, 0, 32767, 0, 0, 32767, 28, 29, 30));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (grasp_table[i])
        begin
            send_request(grasp_table[i]);
            idle_gap();
        end
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            send_request(random_row());
            idle_gap();
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (pending_poses.size() != 0 && wait_cycles < 10 * LATENCY)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 5) @(posedge clk);

        if (pending_poses.size() != 0)
            mismatch_count += pending_poses.size();
        $display("covered %0d table rows and %0d random requests", grasp_table.size(),
                 NUM_RANDOM);
        $display("%0d results checked, %0d degenerate, %0d failures", results_seen,
                 degen_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
rtl/gatq_pkg.sv
rtl/grasp_axes_to_quaternion.sv
bench/grasp_axes_to_quaternion_tb.sv
